[design/lmd_pkg.sv]
// lmd_pkg: shared types and constants for the line marker detector
// beat structs for both channels, configuration struct, register indexes
// no dependencies
package lmd_pkg;

    // input beat
    typedef struct packed {
        logic        cmd;
        logic [11:0] left_level;
        logic [11:0] right_level;
        logic [15:0] distance_mm;
        logic [17:0] time_ticks;
    } t_lmd_in;

    // result beat
    typedef struct packed {
        logic        left_marker;
        logic [15:0] left_marker_index;
        logic        right_marker;
        logic [7:0]  right_marker_total;
        logic        junction;
        logic [15:0] junction_index;
        logic [7:0]  junction_total;
        logic        junction_flag;
    } t_lmd_out;

    // configuration registers as seen by the core
    typedef struct packed {
        logic [11:0] on_level;
        logic [11:0] off_level;
        logic [7:0]  confirm_mm;
        logic [7:0]  junction_window_mm;
        logic        record_enable;
    } t_lmd_cfg;

    // configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ON_LEVEL      = 3'd0,
        CFG_OFF_LEVEL     = 3'd1,
        CFG_CONFIRM_MM    = 3'd2,
        CFG_JUNC_WINDOW   = 3'd3,
        CFG_RECORD_ENABLE = 3'd4
    } t_lmd_cfg_idx;

    // command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // register reset values
    localparam logic [11:0] ON_LEVEL_RST      = 12'd400;
    localparam logic [11:0] OFF_LEVEL_RST     = 12'd300;
    localparam logic [7:0]  CONFIRM_MM_RST    = 8'd30;
    localparam logic [7:0]  JUNC_WINDOW_RST   = 8'd40;
    localparam logic        RECORD_ENABLE_RST = 1'b1;

    // log index offsets in time ticks
    localparam logic [17:0] LEFT_LOG_OFFSET = 18'd90;
    localparam logic [17:0] JUNC_LOG_OFFSET = 18'd60;

endpackage

[design/lmd_index.sv]
// lmd_index: log index (time - offset) / 5, zero below the offset
// division by five as a multiply by 2^18/5 rounded up, exact for 18-bit values
// depends on lmd_pkg
module lmd_index (
    input  logic [17:0] i_time_ticks,
    input  logic [17:0] i_offset,
    output logic [15:0] o_index
);
    import lmd_pkg::*;

    // ceil(2^18 / 5); 5 * 52429 = 2^18 + 1 keeps the error below one fifth
    localparam logic [15:0] RECIP_5 = 16'd52429;

    logic [17:0] diff;
    logic [33:0] prod;

    // clamp then scale
    always_comb begin
        if (i_time_ticks < i_offset) begin
            diff = 18'd0;
        end else begin
            diff = i_time_ticks - i_offset;
        end
        prod    = {16'd0, diff} * {18'd0, RECIP_5};
        o_index = prod[33:18];
    end

endmodule

[design/lmd_core.sv]
// lmd_core: detector state and the single-pass update for one tick
// left side evaluated in full before the right side
// depends on lmd_pkg and lmd_index
module lmd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  lmd_pkg::t_lmd_in  i_beat,
    input  lmd_pkg::t_lmd_cfg i_cfg,
    output lmd_pkg::t_lmd_out o_res
);
    import lmd_pkg::*;

    // state
    logic        r_left_high,  n_left_high;
    logic        r_left_pend,  n_left_pend;
    logic        r_right_high, n_right_high;
    logic        r_right_pend, n_right_pend;
    logic [15:0] r_left_fall,  n_left_fall;
    logic [15:0] r_right_fall, n_right_fall;
    logic [7:0]  r_right_cnt,  n_right_cnt;
    logic [7:0]  r_junc_cnt,   n_junc_cnt;
    logic        r_junc_seen,  n_junc_seen;

    logic [15:0] left_idx_raw;
    logic [15:0] junc_idx_raw;

    // shorter way round between the two fall points, below the window
    function automatic logic in_window(input logic [15:0] a, input logic [15:0] b,
                                       input logic [7:0] win);
        logic [15:0] d;
        d = a - b;
        if (d[15]) begin
            d = 16'd0 - d;
        end
        return d < {8'd0, win};
    endfunction

    lmd_index u_left_idx (
        .i_time_ticks (i_beat.time_ticks),
        .i_offset     (LEFT_LOG_OFFSET),
        .o_index      (left_idx_raw)
    );

    lmd_index u_junc_idx (
        .i_time_ticks (i_beat.time_ticks),
        .i_offset     (JUNC_LOG_OFFSET),
        .o_index      (junc_idx_raw)
    );

    // next state and result for this tick
    always_comb begin
        logic ev_left;
        logic ev_right;
        logic ev_junc;
        logic [15:0] cur_dist;

        ev_left  = 1'b0;
        ev_right = 1'b0;
        ev_junc  = 1'b0;
        cur_dist = i_beat.distance_mm;

        n_left_high  = r_left_high;
        n_left_pend  = r_left_pend;
        n_right_high = r_right_high;
        n_right_pend = r_right_pend;
        n_left_fall  = r_left_fall;
        n_right_fall = r_right_fall;
        n_right_cnt  = r_right_cnt;
        n_junc_cnt   = r_junc_cnt;
        n_junc_seen  = r_junc_seen;
        o_res        = '0;

        if (i_beat.cmd == CMD_CLEAR) begin
            n_left_high  = 1'b0;
            n_left_pend  = 1'b0;
            n_right_high = 1'b0;
            n_right_pend = 1'b0;
            n_left_fall  = 16'd0;
            n_right_fall = 16'd0;
            n_right_cnt  = 8'd0;
            n_junc_cnt   = 8'd0;
            n_junc_seen  = 1'b0;
        end else begin
            // left side: rise, fall with junction check, confirm
            if (i_beat.left_level >= i_cfg.on_level) begin
                n_left_high = 1'b1;
                n_left_pend = 1'b0;
            end
            if (i_beat.left_level <= i_cfg.off_level && n_left_high) begin
                n_left_high = 1'b0;
                n_left_pend = 1'b1;
                n_left_fall = cur_dist;
                if (n_right_pend) begin
                    if (in_window(n_left_fall, n_right_fall, i_cfg.junction_window_mm))
                    begin
                        ev_junc = 1'b1;
                    end
                    n_left_pend  = 1'b0;
                    n_right_pend = 1'b0;
                end
            end
            if (n_left_pend && (cur_dist - n_left_fall) > {8'd0, i_cfg.confirm_mm}) begin
                n_left_pend = 1'b0;
                n_junc_seen = 1'b0;
                ev_left     = 1'b1;
            end

            // right side
            if (i_beat.right_level >= i_cfg.on_level) begin
                n_right_high = 1'b1;
                n_right_pend = 1'b0;
            end
            if (i_beat.right_level <= i_cfg.off_level && n_right_high) begin
                n_right_high = 1'b0;
                n_right_pend = 1'b1;
                n_right_fall = cur_dist;
                if (n_left_pend) begin
                    if (in_window(n_left_fall, n_right_fall, i_cfg.junction_window_mm))
                    begin
                        ev_junc = 1'b1;
                    end
                    n_left_pend  = 1'b0;
                    n_right_pend = 1'b0;
                end
            end
            if (n_right_pend && (cur_dist - n_right_fall) > {8'd0, i_cfg.confirm_mm}) begin
                n_right_pend = 1'b0;
                n_junc_seen  = 1'b0;
                ev_right     = 1'b1;
                if (n_right_cnt != 8'hFF) begin
                    n_right_cnt = n_right_cnt + 8'd1;
                end
            end

            // at most one junction per tick, the fall check clears both sides
            if (ev_junc) begin
                n_junc_seen = 1'b1;
                if (n_junc_cnt != 8'hFF) begin
                    n_junc_cnt = n_junc_cnt + 8'd1;
                end
            end

            o_res.left_marker        = ev_left;
            o_res.left_marker_index  = (ev_left && i_cfg.record_enable) ? left_idx_raw : 16'd0;
            o_res.right_marker       = ev_right;
            o_res.right_marker_total = n_right_cnt;
            o_res.junction           = ev_junc;
            o_res.junction_index     = (ev_junc && i_cfg.record_enable) ? junc_idx_raw : 16'd0;
            o_res.junction_total     = n_junc_cnt;
            o_res.junction_flag      = n_junc_seen;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_high  <= 1'b0;
            r_left_pend  <= 1'b0;
            r_right_high <= 1'b0;
            r_right_pend <= 1'b0;
            r_left_fall  <= 16'd0;
            r_right_fall <= 16'd0;
            r_right_cnt  <= 8'd0;
            r_junc_cnt   <= 8'd0;
            r_junc_seen  <= 1'b0;
        end else if (i_step) begin
            r_left_high  <= n_left_high;
            r_left_pend  <= n_left_pend;
            r_right_high <= n_right_high;
            r_right_pend <= n_right_pend;
            r_left_fall  <= n_left_fall;
            r_right_fall <= n_right_fall;
            r_right_cnt  <= n_right_cnt;
            r_junc_cnt   <= n_junc_cnt;
            r_junc_seen  <= n_junc_seen;
        end
    end

    // a side is never on the marker and pending at once
    a_left_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_left_high && r_left_pend))
        else $error("left side high and pending together");

    a_right_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_right_high && r_right_pend))
        else $error("right side high and pending together");

    // the junction count only changes on a tick
    a_junc_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_junc_cnt))
        else $error("junction count changed without a tick");

endmodule

[design/line_marker_detector.sv]
// line_marker_detector: top level with configuration registers and beat registers
// depends on lmd_pkg and lmd_core
//
// Takes one sensor beat per clock cycle while not stalled and returns exactly one result
// beat for it: the beat is captured in an input register, and the whole
// tick update (level compares, fall distance checks, junction test and the log index
// multiply) runs in one pass to the result register. The result register and input
// register let a new beat enter while a result waits to be taken, so with no stall
// the rate is one beat per cycle. The user must write configuration through the plain write
// port only while the block is idle; the block does not enforce it. A clear command beat
// resets all detector state and counts and returns all zeros. No clearing pass after reset.
module line_marker_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  lmd_pkg::t_lmd_in                  i_data,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output lmd_pkg::t_lmd_out                 o_data,
    // configuration port
    input  logic                              i_cfg_we,
    input  logic [lmd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lmd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lmd_pkg::*;

    t_lmd_cfg r_cfg;
    t_lmd_in  r_in;
    logic     r_in_valid;
    t_lmd_out r_out;
    logic     r_out_valid;
    t_lmd_out res;
    logic     advance;
    logic     step;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_level           <= ON_LEVEL_RST;
            r_cfg.off_level          <= OFF_LEVEL_RST;
            r_cfg.confirm_mm         <= CONFIRM_MM_RST;
            r_cfg.junction_window_mm <= JUNC_WINDOW_RST;
            r_cfg.record_enable      <= RECORD_ENABLE_RST;
        end else if (i_cfg_we) begin
            unique case (t_lmd_cfg_idx'(i_cfg_idx))
                CFG_ON_LEVEL:      r_cfg.on_level           <= i_cfg_data;
                CFG_OFF_LEVEL:     r_cfg.off_level          <= i_cfg_data;
                CFG_CONFIRM_MM:    r_cfg.confirm_mm         <= i_cfg_data[7:0];
                CFG_JUNC_WINDOW:   r_cfg.junction_window_mm <= i_cfg_data[7:0];
                CFG_RECORD_ENABLE: r_cfg.record_enable      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // pipeline flow
    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = !i_rst_n || (r_in_valid && !advance);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_data;
        end
    end

    lmd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_beat  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // a junction beat carries the flag and a nonzero total
    a_junc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.junction |-> r_out.junction_flag && r_out.junction_total != 8'd0)
        else $error("junction without flag or count");

    // a marker confirmation excludes a junction and clears the flag
    a_marker_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.left_marker || r_out.right_marker)
            |-> !r_out.junction && !r_out.junction_flag)
        else $error("marker beat with junction or flag");

    // a beat that moves on arrives in the result register
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("beat lost between input and result register");

endmodule

[sim/line_marker_detector_tb.sv]
`timescale 1ns / 1ps
// line_marker_detector_tb: self-checking bench for the line marker detector
// directed table then random phases under several register settings, every result beat checked
// depends on lmd_pkg and line_marker_detector
module line_marker_detector_tb;
    import lmd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS     = 25;

    typedef enum logic {GEN_MARKS, GEN_RIGHT_SAT} t_gen_mode;

    // one row of the directed table
    typedef struct {
        t_lmd_in  beat;
        bit       typed;
        t_lmd_out want;
    } t_dir_row;

    // block ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_lmd_in               i_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_lmd_out              o_data;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // expected result beats, oldest first
    t_lmd_out due_results[$];

    // detector state as predicted
    t_lmd_cfg    model_cfg = '{ON_LEVEL_RST, OFF_LEVEL_RST, CONFIRM_MM_RST,
                               JUNC_WINDOW_RST, RECORD_ENABLE_RST};
    bit          m_lhigh = 0, m_lpend = 0, m_rhigh = 0, m_rpend = 0, m_jseen = 0;
    logic [15:0] m_lfall = '0, m_rfall = '0;
    logic [7:0]  m_rcount = '0, m_jcount = '0;
    bit          m_jev;
    logic [15:0] m_jidx;

    // run bookkeeping
    int          mismatches = 0, beats_checked = 0, cycle_count = 0;
    int          left_seen = 0, right_seen = 0, junc_seen = 0, clears_sent = 0;
    int          settings_used = 1;
    int          hold_asked = 0;
    bit          tx_idling = 1, rx_idling = 1, calm = 0;
    logic [15:0] dist_now = '0;
    logic [17:0] time_now = '0;
    t_dir_row    dir_rows[DIR_ROWS];
    t_lmd_out    want_beat;
    string       diffs;

    line_marker_detector DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // log index from the time counter, clamped at zero
    function automatic logic [15:0] stamp_index(logic [17:0] t, logic [17:0] offset);
        logic [17:0] q;
        if (t < offset) return '0;
        q = (t - offset) / 18'd5;
        return q[15:0];
    endfunction

    // both sides pending: compare fall distances the short way round
    function automatic void junction_check(logic [17:0] t);
        logic [15:0] d;
        if (!(m_lpend && m_rpend)) return;
        d = m_lfall - m_rfall;
        if (d >= 16'h8000) d = 16'h0000 - d;
        if (d < model_cfg.junction_window_mm) begin
            if (m_jcount != 8'd255) m_jcount = m_jcount + 8'd1;
            m_jseen = 1;
            m_jev   = 1;
            m_jidx  = model_cfg.record_enable ? stamp_index(t, JUNC_LOG_OFFSET) : '0;
        end
        m_lpend = 0;
        m_rpend = 0;
    endfunction

    // expected result for one sensor beat, left side first
    function automatic t_lmd_out marker_predict(t_lmd_in b);
        t_lmd_out    res;
        logic [15:0] gap;
        res   = '0;
        m_jev = 0;
        m_jidx = '0;
        if (b.cmd == CMD_CLEAR) begin
            m_lhigh = 0; m_lpend = 0; m_rhigh = 0; m_rpend = 0; m_jseen = 0;
            m_lfall = '0; m_rfall = '0; m_rcount = '0; m_jcount = '0;
            return res;
        end
        // left side
        if (b.left_level >= model_cfg.on_level) begin
            m_lhigh = 1;
            m_lpend = 0;
        end
        if (b.left_level <= model_cfg.off_level && m_lhigh) begin
            m_lhigh = 0;
            m_lpend = 1;
            m_lfall = b.distance_mm;
            junction_check(b.time_ticks);
        end
        gap = b.distance_mm - m_lfall;
        if (m_lpend && gap > model_cfg.confirm_mm) begin
            m_lpend = 0;
            m_jseen = 0;
            res.left_marker = 1'b1;
            res.left_marker_index = model_cfg.record_enable ?
                stamp_index(b.time_ticks, LEFT_LOG_OFFSET) : '0;
        end
        // right side
        if (b.right_level >= model_cfg.on_level) begin
            m_rhigh = 1;
            m_rpend = 0;
        end
        if (b.right_level <= model_cfg.off_level && m_rhigh) begin
            m_rhigh = 0;
            m_rpend = 1;
            m_rfall = b.distance_mm;
            junction_check(b.time_ticks);
        end
        gap = b.distance_mm - m_rfall;
        if (m_rpend && gap > model_cfg.confirm_mm) begin
            m_rpend = 0;
            m_jseen = 0;
            res.right_marker = 1'b1;
            if (m_rcount != 8'd255) m_rcount = m_rcount + 8'd1;
        end
        res.right_marker_total = m_rcount;
        res.junction           = m_jev;
        res.junction_index     = m_jidx;
        res.junction_total     = m_jcount;
        res.junction_flag      = m_jseen;
        return res;
    endfunction

    function automatic t_dir_row dir_row(logic cmd, int ll, int rl, int d, int t, bit typed);
        t_dir_row r;
        r.beat.cmd         = cmd;
        r.beat.left_level  = 12'(ll);
        r.beat.right_level = 12'(rl);
        r.beat.distance_mm = 16'(d);
        r.beat.time_ticks  = 18'(t);
        r.typed            = typed;
        r.want             = '0;
        return r;
    endfunction

    // offer one beat, wait for acceptance, then queue what it should produce
    task automatic send_beat(input t_lmd_in b, input bit typed, input t_lmd_out typed_want);
        int       gap;
        t_lmd_out pred;
        if (tx_idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pred = marker_predict(b);
        due_results.push_back(typed ? typed_want : pred);
        if (b.cmd == CMD_CLEAR) clears_sent++;
        if (pred.left_marker) left_seen++;
        if (pred.right_marker) right_seen++;
        if (pred.junction) junc_seen++;
    endtask

    // stop offering and let every outstanding result come back
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_lmd_cfg_idx idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ON_LEVEL:      model_cfg.on_level = val;
            CFG_OFF_LEVEL:     model_cfg.off_level = val;
            CFG_CONFIRM_MM:    model_cfg.confirm_mm = val[7:0];
            CFG_JUNC_WINDOW:   model_cfg.junction_window_mm = val[7:0];
            CFG_RECORD_ENABLE: model_cfg.record_enable = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [11:0] on_lv, input logic [11:0] off_lv,
                                  input logic [7:0] conf, input logic [7:0] win,
                                  input logic rec);
        write_reg(CFG_ON_LEVEL, on_lv);
        write_reg(CFG_OFF_LEVEL, off_lv);
        write_reg(CFG_CONFIRM_MM, {4'd0, conf});
        write_reg(CFG_JUNC_WINDOW, {4'd0, win});
        write_reg(CFG_RECORD_ENABLE, {11'd0, rec});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // random phase: marker-shaped level sequences with some noise and clears
    task automatic run_phase(input int count, input t_gen_mode mode, input int step_max,
                             input int clear_pm, input bit hold_mid);
        int          i, run_len, lag;
        bit          shared_hi, l_hi, r_hi;
        logic [1:0]  mask;
        logic [2:0]  hist;
        t_lmd_in     b;
        run_len = 0;
        lag = 0;
        shared_hi = 0;
        mask = 2'b11;
        hist = '0;
        for (i = 0; i < count; i++) begin
            if (i % 40 == 0 && !calm) begin
                tx_idling = $urandom_range(0, 3) != 0;
                rx_idling = $urandom_range(0, 3) != 0;
            end
            if (hold_mid && i == count / 2) hold_asked++;
            b = '0;
            b.cmd = CMD_TICK;
            if (mode == GEN_RIGHT_SAT) begin
                // fall on one beat, confirm on the next, left never rises
                b.left_level  = 12'($urandom_range(0, model_cfg.on_level - 1));
                b.right_level = (i % 2 == 0) ? model_cfg.on_level :
                                12'($urandom_range(0, model_cfg.on_level - 1));
                dist_now = dist_now + 16'($urandom_range(1, 9));
            end else begin
                if (run_len == 0) begin
                    shared_hi = !shared_hi;
                    run_len = shared_hi ? $urandom_range(1, 3) : $urandom_range(1, 8);
                    if (shared_hi) begin
                        mask = 2'($urandom_range(0, 3));
                        lag  = $urandom_range(0, 2);
                    end
                end
                run_len--;
                hist = {hist[1:0], shared_hi};
                l_hi = mask[0] && hist[0];
                r_hi = mask[1] && hist[lag];
                b.left_level  = l_hi ? 12'($urandom_range(4095, model_cfg.on_level)) :
                                12'($urandom_range(0, model_cfg.off_level));
                b.right_level = r_hi ? 12'($urandom_range(4095, model_cfg.on_level)) :
                                12'($urandom_range(0, model_cfg.off_level));
                if ($urandom_range(0, 9) == 0) b.left_level = 12'($urandom);
                if ($urandom_range(0, 9) == 0) b.right_level = 12'($urandom);
                if ($urandom_range(0, 32) == 0) dist_now = 16'($urandom);
                else dist_now = dist_now + 16'($urandom_range(0, step_max));
                if ($urandom_range(0, 999) < clear_pm) b.cmd = CMD_CLEAR;
            end
            if ($urandom_range(0, 32) == 0) time_now = 18'($urandom);
            else time_now = time_now + 18'($urandom_range(1, 6));
            b.distance_mm = dist_now;
            b.time_ticks  = time_now;
            send_beat(b, 1'b0, '0);
        end
    endtask

    task automatic note_field(input string fname, input logic [15:0] got,
                              input logic [15:0] want);
        if (got !== want) diffs = {diffs, " ", fname};
    endtask

    // result side: compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", o_data);
            end else begin
                want_beat = due_results.pop_front();
                diffs = "";
                note_field("left_marker", 16'(o_data.left_marker),
                           16'(want_beat.left_marker));
                note_field("left_marker_index", o_data.left_marker_index,
                           want_beat.left_marker_index);
                note_field("right_marker", 16'(o_data.right_marker),
                           16'(want_beat.right_marker));
                note_field("right_marker_total", 16'(o_data.right_marker_total),
                           16'(want_beat.right_marker_total));
                note_field("junction", 16'(o_data.junction), 16'(want_beat.junction));
                note_field("junction_index", o_data.junction_index, want_beat.junction_index);
                note_field("junction_total", 16'(o_data.junction_total),
                           16'(want_beat.junction_total));
                note_field("junction_flag", 16'(o_data.junction_flag),
                           16'(want_beat.junction_flag));
                if (diffs != "") begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch on beat %0d in%s: expected %h got %h",
                                 beats_checked, diffs, want_beat, o_data);
                end
                beats_checked++;
            end
        end
    end

    // receiver stall: random bursts plus long hold-offs on request
    initial begin : rx_side
        int hold_left, burst_left, hold_done;
        hold_left = 0;
        burst_left = 0;
        hold_done = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_asked != hold_done) begin
                hold_done = hold_asked;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (rx_idling && !calm && $urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(1, 12) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_results.size());
            $display("FAIL line_marker_detector");
            $finish;
        end
    end

    // stimulus
    initial begin : stim
        int r, on_r, off_r;
        // directed table under reset settings
        dir_rows[0]  = dir_row(CMD_CLEAR, 4095, 4095, 65535, 262143, 1);
        dir_rows[1]  = dir_row(CMD_TICK, 0, 0, 0, 0, 1);
        dir_rows[2]  = dir_row(CMD_TICK, 4095, 0, 100, 1000, 1);
        dir_rows[3]  = dir_row(CMD_TICK, 300, 0, 110, 1005, 1);
        dir_rows[4]  = dir_row(CMD_TICK, 0, 0, 140, 1010, 1);
        dir_rows[5]  = dir_row(CMD_TICK, 0, 0, 141, 1015, 0);
        dir_rows[6]  = dir_row(CMD_TICK, 0, 400, 200, 1020, 0);
        dir_rows[7]  = dir_row(CMD_TICK, 0, 299, 210, 1025, 0);
        dir_rows[8]  = dir_row(CMD_TICK, 0, 0, 250, 1030, 0);
        // both sides fall together, junction before the index offset
        dir_rows[9]  = dir_row(CMD_TICK, 4095, 4095, 500, 59, 0);
        dir_rows[10] = dir_row(CMD_TICK, 0, 0, 505, 59, 0);
        dir_rows[11] = dir_row(CMD_TICK, 399, 301, 600, 89, 0);
        // left marker confirmed before its index offset
        dir_rows[12] = dir_row(CMD_TICK, 4095, 0, 1000, 89, 0);
        dir_rows[13] = dir_row(CMD_TICK, 0, 0, 1000, 89, 0);
        dir_rows[14] = dir_row(CMD_TICK, 0, 0, 1031, 89, 0);
        // junction across the distance wrap at the top of the time counter
        dir_rows[15] = dir_row(CMD_TICK, 4095, 0, 65520, 90, 0);
        dir_rows[16] = dir_row(CMD_TICK, 0, 0, 65530, 90, 0);
        dir_rows[17] = dir_row(CMD_TICK, 0, 4095, 65535, 95, 0);
        dir_rows[18] = dir_row(CMD_TICK, 0, 0, 5, 262143, 0);
        // fall difference equal to the window: no junction, both marks dropped
        dir_rows[19] = dir_row(CMD_TICK, 4095, 4095, 2000, 3000, 0);
        dir_rows[20] = dir_row(CMD_TICK, 4095, 0, 2000, 3000, 0);
        dir_rows[21] = dir_row(CMD_TICK, 0, 0, 2040, 3000, 0);
        dir_rows[22] = dir_row(CMD_TICK, 0, 0, 2100, 3005, 0);
        dir_rows[23] = dir_row(CMD_CLEAR, 0, 0, 0, 0, 1);
        dir_rows[24] = dir_row(CMD_TICK, 0, 0, 0, 0, 1);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
            send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
        settle();

        // reset values written back, long receiver hold-off midway
        apply_settings(12'd400, 12'd300, 8'd30, 8'd40, 1'b1);
        run_phase(80, GEN_MARKS, 12, 20, 1);
        settle();

        // extremes: hardest to reach marks, indices off
        apply_settings(12'd4095, 12'd0, 8'd255, 8'd255, 1'b0);
        run_phase(40, GEN_MARKS, 60, 20, 0);
        settle();

        // every level rises and falls: junction count saturates
        apply_settings(12'd0, 12'd4095, 8'd0, 8'd255, 1'b1);
        run_phase(258, GEN_MARKS, 12, 0, 0);
        settle();

        // overlapping levels, right marker count saturates
        apply_settings(12'd2048, 12'd2048, 8'd0, 8'd0, 1'b0);
        run_phase(512, GEN_RIGHT_SAT, 0, 0, 0);
        settle();

        // random settings with off at or above on
        on_r  = $urandom_range(100, 2000);
        off_r = $urandom_range(on_r, 4095);
        apply_settings(12'(on_r), 12'(off_r), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        run_phase(20, GEN_MARKS, 15, 20, 0);
        settle();

        // fully random settings
        apply_settings(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       8'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        run_phase(20, GEN_MARKS, 15, 20, 0);
        settle();

        // closing stretch with no idling on either side
        calm = 1;
        tx_idling = 0;
        rx_idling = 0;
        apply_settings(12'd1000, 12'd700, 8'd10, 8'd20, 1'b1);
        run_phase(20, GEN_MARKS, 6, 20, 0);
        settle();

        $display("checked %0d result beats under %0d register settings, %0d clears",
                 beats_checked, settings_used, clears_sent);
        $display("left markers %0d, right markers %0d, junctions %0d, mismatches %0d",
                 left_seen, right_seen, junc_seen, mismatches);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("PASS line_marker_detector");
        end else begin
            $display("FAIL line_marker_detector");
        end
        $finish;
    end

endmodule
